FILE: design/ibt_pkg.sv
package ibt_pkg;

	// fixed widths of the port fields
	localparam int FIELD_W  = 32;
	localparam int STATUS_W = 2;

	// default sizing of the table
	localparam int CAPACITY_DEF   = 64;
	localparam int TIME_WIDTH_DEF = 32;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_BOOKED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// request sequencer
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_DEC
	} state_t;

	// control handed from the sequencer to every cell
	typedef struct packed {
		logic shift;
	} cell_ctl_t;

endpackage

FILE: design/ibt_cell.sv
module ibt_cell #(
	parameter int TIME_WIDTH = ibt_pkg::TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ibt_pkg::cell_ctl_t    ctl,
	input  logic [TIME_WIDTH-1:0] prev_beg,
	input  logic [TIME_WIDTH-1:0] prev_fin,
	input  logic                  prev_vld,
	input  logic [TIME_WIDTH-1:0] req_lo,
	input  logic [TIME_WIDTH-1:0] req_hi,
	output logic [TIME_WIDTH-1:0] entry_beg,
	output logic [TIME_WIDTH-1:0] entry_fin,
	output logic                  entry_vld,
	output logic                  hit
);
	import ibt_pkg::*;

	logic [TIME_WIDTH-1:0] beg_q;
	logic [TIME_WIDTH-1:0] fin_q;
	logic                  vld_q;
	logic                  hit_q;

	// stored range, taken from the left neighbour on an insert
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			beg_q <= prev_beg;
			fin_q <= prev_fin;
		end
	end

	// occupancy flag travels with the range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= prev_vld;
		end
	end

	// half-open overlap test against the pending request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= vld_q && (beg_q < req_hi) && (req_lo < fin_q);
		end
	end

	assign entry_beg = beg_q;
	assign entry_fin = fin_q;
	assign entry_vld = vld_q;
	assign hit       = hit_q;

endmodule

FILE: design/interval_booking_table.sv
// Reservation table for half-open time ranges [range_start, range_end). Each request is
// checked against every stored range at once by a row of CAPACITY cells, one range per
// cell; a request that overlaps nothing is pushed into the head of the row while the
// older ranges move one cell along, and is reported as booked. Status is 0 booked,
// 1 overlap, 2 table full (request not stored), 3 inverted range (start above end).
// Overlap takes priority over full. Ranges are only removed by reset. A result is
// registered after its input transfer passes the registered cell compare and then the
// decision and insert step, and the sequencer returns to its idle state before taking
// the next request, so it takes no new request until it is through with the last one; a
// stalled output holds the decision step for as long as it stalls. A new request may be
// accepted while the previous result still waits on the output.
module interval_booking_table #(
	parameter int CAPACITY   = ibt_pkg::CAPACITY_DEF,
	parameter int TIME_WIDTH = ibt_pkg::TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ibt_pkg::FIELD_W-1:0]   range_start,
	input  logic [ibt_pkg::FIELD_W-1:0]   range_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ibt_pkg::STATUS_W-1:0]  status
);
	import ibt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t                state_q, state_d;
	logic [TIME_WIDTH-1:0] lo_q, hi_q;
	logic [CW-1:0]         cnt_q;
	logic                  out_valid_q;
	status_t               status_q;
	status_t               verdict;
	cell_ctl_t             ctl;
	logic                  load_out;
	logic                  out_free;

	logic [TIME_WIDTH-1:0] beg_w [CAPACITY];
	logic [TIME_WIDTH-1:0] fin_w [CAPACITY];
	logic [CAPACITY-1:0]   vld_w;
	logic [CAPACITY-1:0]   hit_w;

	// row of cells, the newest range enters at cell zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			ibt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev_beg  (lo_q),
				.prev_fin  (hi_q),
				.prev_vld  (1'b1),
				.req_lo    (lo_q),
				.req_hi    (hi_q),
				.entry_beg (beg_w[i]),
				.entry_fin (fin_w[i]),
				.entry_vld (vld_w[i]),
				.hit       (hit_w[i])
			);
		end else begin : g_body
			ibt_cell #(.TIME_WIDTH(TIME_WIDTH)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev_beg  (beg_w[i-1]),
				.prev_fin  (fin_w[i-1]),
				.prev_vld  (vld_w[i-1]),
				.req_lo    (lo_q),
				.req_hi    (hi_q),
				.entry_beg (beg_w[i]),
				.entry_fin (fin_w[i]),
				.entry_vld (vld_w[i]),
				.hit       (hit_w[i])
			);
		end
	end

	// request capture, reduced to the table's time width
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lo_q <= TIME_WIDTH'(range_start);
			hi_q <= TIME_WIDTH'(range_end);
		end
	end

	// verdict from the cell hits and the fill count
	always_comb begin
		if (lo_q > hi_q) begin
			verdict = ST_INVALID;
		end else if (|hit_w) begin
			verdict = ST_OVERLAP;
		end else if (cnt_q == CW'(CAPACITY)) begin
			verdict = ST_FULL;
		end else begin
			verdict = ST_BOOKED;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		load_out  = 1'b0;
		ctl.shift = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = S_DEC;
			end
			S_DEC: begin
				if (out_free) begin
					load_out  = 1'b1;
					ctl.shift = (verdict == ST_BOOKED);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.shift) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// fill count never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// occupied cells always match the fill count
	a_cnt_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_w) == int'(cnt_q))
		else $error("occupied cells disagree with fill count");

	// a booked result always grows the table by one
	a_book_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && verdict == ST_BOOKED) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("booking did not store the range");

	// a result is only produced out of the decision step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DEC)
		else $error("result raised outside the decision step");

endmodule

FILE: verif/tb_interval_booking_table.sv
`timescale 1ns / 100ps

module tb_interval_booking_table;
	import ibt_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int TIME_W = TIME_WIDTH_DEF;
	localparam logic [FIELD_W-1:0] TIME_MASK = {FIELD_W{1'b1}} >> (FIELD_W - TIME_W);
	localparam longint WIN_BASE = 1000;
	localparam int WIN_SPAN = 40000;
	localparam int SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [FIELD_W-1:0] range_start;
	logic [FIELD_W-1:0] range_end;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;

	// predicted contents of the reservation table
	logic [FIELD_W-1:0] booked_lo [CAPACITY];
	logic [FIELD_W-1:0] booked_hi [CAPACITY];
	int booked_count = 0;

	status_t status_due [$];
	int status_tally [4] = '{0, 0, 0, 0};
	int error_count = 0;
	int request_count = 0;
	bit quiet_run = 1'b0;

	interval_booking_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.range_start(range_start),
		.range_end(range_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status)
	);

	always #5 clk = ~clk;

	// status of one request against the predicted table, booking it when it fits
	function automatic status_t book_predict(input logic [FIELD_W-1:0] s,
			input logic [FIELD_W-1:0] e);
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		bit clash;
		lo = s & TIME_MASK;
		hi = e & TIME_MASK;
		clash = 1'b0;
		if (lo > hi) return ST_INVALID;
		for (int i = 0; i < booked_count; i++) begin
			if (booked_lo[i] < hi && lo < booked_hi[i]) clash = 1'b1;
		end
		if (clash) return ST_OVERLAP;
		if (booked_count >= CAPACITY) return ST_FULL;
		booked_lo[booked_count] = lo;
		booked_hi[booked_count] = hi;
		booked_count++;
		return ST_BOOKED;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_time(input longint v);
		if (v < 0) return '0;
		if (v > longint'(TIME_MASK)) return TIME_MASK;
		return v[FIELD_W-1:0];
	endfunction

	// one request transfer, with random idle cycles in front of it
	task automatic send_request(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
		status_t st;
		while (!quiet_run && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		range_start <= lo;
		range_end <= hi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		st = book_predict(lo, hi);
		status_due = {status_due, st};
		status_tally[st]++;
		request_count++;
	endtask

	// hold the sender until every status has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random request: fresh ranges, ranges aimed at stored entries, empties, inverted
	task automatic make_request(input bit fresh_only, output logic [FIELD_W-1:0] lo,
			output logic [FIELD_W-1:0] hi);
		int pick;
		int k;
		longint b;
		longint f;
		longint a;
		logic [FIELD_W-1:0] tmp;
		pick = fresh_only ? 20 : $urandom_range(0, 99);
		if (pick < 10) begin
			// inverted, over the full width
			lo = $urandom();
			hi = $urandom();
			if (lo < hi) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end else if (lo == hi) begin
				if (hi == '0) lo = 1;
				else hi = hi - 1;
			end
		end else if (pick < 40 || booked_count == 0) begin
			// fresh range, mostly in the busy window
			if ($urandom_range(0, 9) == 0) b = {32'd0, $urandom()};
			else b = WIN_BASE + $urandom_range(0, WIN_SPAN);
			f = b + $urandom_range(0, 300);
			lo = clamp_time(b);
			hi = clamp_time(f);
		end else if (pick < 50) begin
			// empty range somewhere in the window
			lo = clamp_time(WIN_BASE + $urandom_range(0, WIN_SPAN));
			hi = lo;
		end else begin
			k = $urandom_range(0, booked_count - 1);
			b = {32'd0, booked_lo[k]};
			f = {32'd0, booked_hi[k]};
			case ($urandom_range(0, 5))
				0: begin
					// abutting after the entry
					lo = clamp_time(f);
					hi = clamp_time(f + $urandom_range(0, 60));
				end
				1: begin
					// abutting before the entry
					lo = clamp_time(b - $urandom_range(0, 60));
					hi = clamp_time(b);
				end
				2: begin
					// straddling the entry start
					lo = clamp_time(b - 1 - $urandom_range(0, 40));
					hi = clamp_time(b + 1 + $urandom_range(0, 40));
				end
				3: begin
					// starting inside or just past the entry
					a = b + $urandom_range(0, 40);
					lo = clamp_time(a);
					hi = clamp_time(a + 1 + $urandom_range(0, 40));
				end
				4: begin
					// empty range on or inside the entry
					a = b + $urandom_range(0, int'(f - b));
					lo = clamp_time(a);
					hi = lo;
				end
				default: begin
					lo = booked_lo[k];
					hi = booked_hi[k];
				end
			endcase
		end
	endtask

	// boundaries, empties, inversion and overlap shapes
	task automatic test_directed_cases();
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'h0000_0000, 32'h0000_0000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF, 32'h0000_0000);
		send_request(32'h0000_0001, 32'h0000_0000);
		send_request(32'd100, 32'd200);
		send_request(32'd200, 32'd300);
		send_request(32'd50, 32'd100);
		send_request(32'd150, 32'd160);
		send_request(32'd99, 32'd101);
		send_request(32'd100, 32'd300);
		send_request(32'd150, 32'd150);
		send_request(32'd100, 32'd100);
		send_request(32'd300, 32'd300);
		send_request(32'h8000_0000, 32'hFFFF_FFFE);
		send_request(32'h7FFF_FFFF, 32'h8000_0001);
		send_request(32'h5555_5555, 32'hAAAA_AAAA);
		send_request(32'hAAAA_AAAA, 32'h5555_5555);
		send_request(32'h0000_0000, 32'hFFFF_FFFF);
		send_request(32'h0000_0001, 32'hFFFF_FFFE);
	endtask

	// random traffic while the table fills, with a stall-free stretch and a pause
	task automatic test_random_bookings(input int n);
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		for (int i = 0; i < n; i++) begin
			quiet_run = (i >= 150 && i < 300);
			if (i == 220) wait_drained();
			make_request(1'b0, lo, hi);
			send_request(lo, hi);
		end
		quiet_run = 1'b0;
	endtask

	// top the table up, then overlap-versus-full priority on a full table
	task automatic test_full_table(input int n);
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		int guard;
		guard = 0;
		while (booked_count < CAPACITY && guard < 2000) begin
			make_request(1'b1, lo, hi);
			send_request(lo, hi);
			guard++;
		end
		for (int i = 0; i < n; i++) begin
			make_request(1'b0, lo, hi);
			send_request(lo, hi);
		end
	endtask

	// result check and receiver stall
	always @(posedge clk) begin
		status_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					$error("status: no transfer expected, got %0d", status);
					error_count++;
				end else begin
					want = status_due.pop_front();
					if (status !== want) begin
						$error("status: expected %0d, actual %0d", want, status);
						error_count++;
					end
				end
			end
		end
		out_ready <= quiet_run || ($urandom_range(0, 99) >= 10);
	end

	initial begin
		#5_000_000;
		$display("interval_booking_table regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		range_start = '0;
		range_end = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_bookings(450);
		wait_drained();
		test_full_table(470);
		wait_drained();

		$display("%0d requests: %0d booked, %0d overlapping, %0d refused full, %0d inverted",
			request_count, status_tally[ST_BOOKED], status_tally[ST_OVERLAP],
			status_tally[ST_FULL], status_tally[ST_INVALID]);
		$display("table filled to %0d of %0d entries under random idle and stall",
			booked_count, CAPACITY);
		if (error_count == 0) begin
			$display("interval_booking_table regression: pass");
		end else begin
			$display("interval_booking_table regression: fail");
		end
		$finish;
	end

endmodule
